[src/pfdc_pkg.sv]
// Shared types, widths and codes for the filtered-derivative PID core.
// Used by the register bank, controller, datapath and top level.
`timescale 1ns / 1ps

package pfdc_pkg;

    // Default number of fraction bits in gains and drive
    localparam int FRAC_BITS_DEF = 16;

    // Fixed Q1.16 scaling of filter weight and time step
    localparam int W_SHIFT = 16;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // Operand and product widths
    localparam int DATA_W = 32;   // target, measured, gains
    localparam int ERR_W  = 33;   // error and filter history
    localparam int DE_W   = 34;   // error minus history, filter step
    localparam int ACC_W  = 48;   // integrator and drive
    localparam int MA_W   = 35;   // multiplier wide operand
    localparam int CH_W   = 17;   // digit width of the narrow operand
    localparam int MB_W   = CH_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int OPND_W = 3 * CH_W;
    localparam int TERM_W = 80;   // one gain product, and the running sum

    // Configuration port
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    // Register indexes
    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_FWEIGHT = 3'd3;
    localparam logic [2:0] REG_TSTEP   = 3'd4;
    localparam logic [2:0] REG_INT_MIN = 3'd5;
    localparam logic [2:0] REG_INT_MAX = 3'd6;

    // Register reset values
    localparam logic [16:0]        TSTEP_RST   = 17'd1311;
    localparam logic signed [47:0] INT_MAX_RST = 48'sd65536000000;
    localparam logic signed [47:0] INT_MIN_RST = -48'sd65536000000;

    // Saturation limits of the drive
    localparam logic [47:0] DRIVE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] DRIVE_MIN = 48'h8000_0000_0000;

    // Multiplier operand sources
    localparam logic [2:0] SRC_FILT = 3'd0;
    localparam logic [2:0] SRC_INT  = 3'd1;
    localparam logic [2:0] SRC_P    = 3'd2;
    localparam logic [2:0] SRC_I    = 3'd3;
    localparam logic [2:0] SRC_D    = 3'd4;

    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic [16:0]        fweight;
        logic [16:0]        tstep;
        logic signed [47:0] int_min;
        logic signed [47:0] int_max;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic       load;      // capture a control-step beat
        logic       clear;     // empty integrator and filter history
        logic       diff;      // form error minus history, clear sum
        logic       mul_en;    // issue one multiply
        logic [2:0] src;       // operand source
        logic [1:0] chunk;     // digit of the narrow operand
        logic       first;     // first digit of a gain product
        logic       last;      // top digit of a gain product
        logic       clamp;     // clamp and store the integrator
        logic       sat_load;  // saturate sum into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

[src/pfdc_regs.sv]
// APB-style configuration register bank of the PID core.
// Depends on pfdc_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module pfdc_regs
    import pfdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_AW-1:3];
    assign w_wr   = psel && penable && pwrite;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p  <= '0;
            r_cfg.gain_i  <= '0;
            r_cfg.gain_d  <= '0;
            r_cfg.fweight <= '0;
            r_cfg.tstep   <= TSTEP_RST;
            r_cfg.int_min <= INT_MIN_RST;
            r_cfg.int_max <= INT_MAX_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:  r_cfg.gain_p  <= pwdata[31:0];
                REG_GAIN_I:  r_cfg.gain_i  <= pwdata[31:0];
                REG_GAIN_D:  r_cfg.gain_d  <= pwdata[31:0];
                REG_FWEIGHT: r_cfg.fweight <= pwdata[16:0];
                REG_TSTEP:   r_cfg.tstep   <= pwdata[16:0];
                REG_INT_MIN: r_cfg.int_min <= pwdata[47:0];
                REG_INT_MAX: r_cfg.int_max <= pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    // Read back, zero-extended
    always_comb begin
        unique case (w_idx)
            REG_GAIN_P:  prdata = {32'b0, r_cfg.gain_p};
            REG_GAIN_I:  prdata = {32'b0, r_cfg.gain_i};
            REG_GAIN_D:  prdata = {32'b0, r_cfg.gain_d};
            REG_FWEIGHT: prdata = {47'b0, r_cfg.fweight};
            REG_TSTEP:   prdata = {47'b0, r_cfg.tstep};
            REG_INT_MIN: prdata = {16'b0, r_cfg.int_min};
            REG_INT_MAX: prdata = {16'b0, r_cfg.int_max};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[src/pfdc_ctrl.sv]
// Sequencing state machine of the PID core: accepts beats and issues
// datapath commands. Depends on pfdc_pkg for t_cmd, t_stat and source codes.
`timescale 1ns / 1ps

module pfdc_ctrl
    import pfdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tvalid,
    input  logic  i_tuser,
    output logic  o_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MFILT = 4'd2;
    localparam logic [3:0] S_MINT  = 4'd3;
    localparam logic [3:0] S_MP0   = 4'd4;
    localparam logic [3:0] S_MP1   = 4'd5;
    localparam logic [3:0] S_MI0   = 4'd6;
    localparam logic [3:0] S_MI1   = 4'd7;
    localparam logic [3:0] S_MI2   = 4'd8;
    localparam logic [3:0] S_MD0   = 4'd9;
    localparam logic [3:0] S_MD1   = 4'd10;
    localparam logic [3:0] S_DR1   = 4'd11;
    localparam logic [3:0] S_DR2   = 4'd12;
    localparam logic [3:0] S_SAT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_tready = (r_state == S_IDLE);

    // Advance through the step sequence, holding in S_SAT until the output is free
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (i_tvalid && !i_tuser) ? S_DIFF : S_IDLE;
            S_DIFF:  n_state = S_MFILT;
            S_MFILT: n_state = S_MINT;
            S_MINT:  n_state = S_MP0;
            S_MP0:   n_state = S_MP1;
            S_MP1:   n_state = S_MI0;
            S_MI0:   n_state = S_MI1;
            S_MI1:   n_state = S_MI2;
            S_MI2:   n_state = S_MD0;
            S_MD0:   n_state = S_MD1;
            S_MD1:   n_state = S_DR1;
            S_DR1:   n_state = S_DR2;
            S_DR2:   n_state = S_SAT;
            S_SAT:   n_state = i_stat.out_free ? S_IDLE : S_SAT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands for the current step
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = i_tvalid && !i_tuser;
                o_cmd.clear = i_tvalid && i_tuser;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
            end
            S_MFILT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_FILT;
            end
            S_MINT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_INT;
            end
            S_MP0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_P;
                o_cmd.chunk  = 2'd0;
                o_cmd.first  = 1'b1;
            end
            S_MP1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_P;
                o_cmd.chunk  = 2'd1;
                o_cmd.last   = 1'b1;
                o_cmd.clamp  = 1'b1;
            end
            S_MI0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_I;
                o_cmd.chunk  = 2'd0;
                o_cmd.first  = 1'b1;
            end
            S_MI1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_I;
                o_cmd.chunk  = 2'd1;
            end
            S_MI2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_I;
                o_cmd.chunk  = 2'd2;
                o_cmd.last   = 1'b1;
            end
            S_MD0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_D;
                o_cmd.chunk  = 2'd0;
                o_cmd.first  = 1'b1;
            end
            S_MD1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.src    = SRC_D;
                o_cmd.chunk  = 2'd1;
                o_cmd.last   = 1'b1;
            end
            S_SAT: begin
                o_cmd.sat_load = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[src/pfdc_dp.sv]
// Datapath of the PID core: error, filter, integrator, shared multiplier,
// term accumulation, saturation and output register. Depends on pfdc_pkg.
`timescale 1ns / 1ps

module pfdc_dp
    import pfdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic [DATA_W-1:0] i_target,
    input  logic [DATA_W-1:0] i_measured,
    output t_stat             o_stat,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [ACC_W-1:0]  o_drive
);

    // Working registers
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DE_W-1:0]   r_de;
    logic signed [DE_W-1:0]   r_dd;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ACC_W-1:0]  r_integ;
    logic signed [ACC_W:0]    r_accraw;

    // Product stage and its tag
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic [2:0]               r_psrc;
    logic [1:0]               r_pk;
    logic                     r_pfirst;
    logic                     r_plast;

    // Term and sum accumulators
    logic signed [TERM_W-1:0] r_term;
    logic                     r_cv;
    logic signed [TERM_W-1:0] r_sum;

    // Output register
    logic                     r_ovalid;
    logic [ACC_W-1:0]         r_drive;

    logic [16:0]              w_weight;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [OPND_W-1:0]        w_opnd;
    logic [CH_W-1:0]          w_digit;
    logic signed [DE_W-1:0]   w_pshift;
    logic                     w_is_term;
    logic signed [TERM_W-1:0] w_part;
    logic signed [TERM_W-1:0] w_part_sh;
    logic signed [ACC_W:0]    w_hi;
    logic signed [ACC_W:0]    w_lo;
    logic signed [ACC_W:0]    w_t1;
    logic signed [ACC_W:0]    w_t2;
    logic [TERM_W-ACC_W:0]    w_top;
    logic [ACC_W-1:0]         w_sat;

    // Limit the filter weight to one
    assign w_weight = (i_cfg.fweight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.fweight;

    // Select multiplier operands
    always_comb begin
        case (i_cmd.src)
            SRC_P:   w_opnd = {{(OPND_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            SRC_I:   w_opnd = {{(OPND_W-ACC_W){r_integ[ACC_W-1]}}, r_integ};
            default: w_opnd = {{(OPND_W-DE_W){r_dd[DE_W-1]}}, r_dd};
        endcase
        case (i_cmd.chunk)
            2'd0:    w_digit = w_opnd[CH_W-1:0];
            2'd1:    w_digit = w_opnd[2*CH_W-1:CH_W];
            default: w_digit = w_opnd[3*CH_W-1:2*CH_W];
        endcase
        case (i_cmd.src)
            SRC_FILT: begin
                w_ma = {r_de[DE_W-1], r_de};
                w_mb = {1'b0, w_weight};
            end
            SRC_INT: begin
                w_ma = {{(MA_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_mb = {1'b0, i_cfg.tstep};
            end
            SRC_P: begin
                w_ma = {{(MA_W-DATA_W){i_cfg.gain_p[DATA_W-1]}}, i_cfg.gain_p};
                w_mb = i_cmd.last ? {w_digit[CH_W-1], w_digit} : {1'b0, w_digit};
            end
            SRC_I: begin
                w_ma = {{(MA_W-DATA_W){i_cfg.gain_i[DATA_W-1]}}, i_cfg.gain_i};
                w_mb = i_cmd.last ? {w_digit[CH_W-1], w_digit} : {1'b0, w_digit};
            end
            default: begin
                w_ma = {{(MA_W-DATA_W){i_cfg.gain_d[DATA_W-1]}}, i_cfg.gain_d};
                w_mb = i_cmd.last ? {w_digit[CH_W-1], w_digit} : {1'b0, w_digit};
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Register the product with its tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
        if (i_cmd.mul_en) begin
            r_prod   <= w_prod;
            r_psrc   <= i_cmd.src;
            r_pk     <= i_cmd.chunk;
            r_pfirst <= i_cmd.first;
            r_plast  <= i_cmd.last;
        end
    end

    // Product floored by the Q1.16 scale
    assign w_pshift  = r_prod[W_SHIFT+DE_W-1:W_SHIFT];
    assign w_is_term = (r_psrc == SRC_P) || (r_psrc == SRC_I) || (r_psrc == SRC_D);

    // Error capture, difference, filter step and integrator sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= {i_target[DATA_W-1], i_target} - {i_measured[DATA_W-1], i_measured};
        end
        if (i_cmd.diff) begin
            r_de <= {r_err[ERR_W-1], r_err} - {r_last[ERR_W-1], r_last};
        end
        if (r_pv && r_psrc == SRC_FILT) begin
            r_dd <= w_pshift;
        end
        if (r_pv && r_psrc == SRC_INT) begin
            r_accraw <= {r_integ[ACC_W-1], r_integ}
                      + {{(ACC_W+1-DE_W){w_pshift[DE_W-1]}}, w_pshift};
        end
    end

    // Clamp the integrator: upper bound first, lower bound wins
    assign w_hi = {i_cfg.int_max[ACC_W-1], i_cfg.int_max};
    assign w_lo = {i_cfg.int_min[ACC_W-1], i_cfg.int_min};
    assign w_t1 = (r_accraw > w_hi) ? w_hi : r_accraw;
    assign w_t2 = (w_t1 < w_lo) ? w_lo : w_t1;

    // Controller state: integrator and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_cmd.clear) begin
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.clamp) begin
                r_integ <= w_t2[ACC_W-1:0];
            end
            if (r_pv && r_psrc == SRC_FILT) begin
                r_last <= r_last + w_pshift[ERR_W-1:0];
            end
        end
    end

    // Weight each digit product and build up the gain product
    assign w_part = {{(TERM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        case (r_pk)
            2'd0:    w_part_sh = w_part;
            2'd1:    w_part_sh = w_part <<< CH_W;
            default: w_part_sh = w_part <<< (2 * CH_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_pv && w_is_term && r_plast;
        end
        if (r_pv && w_is_term) begin
            r_term <= (r_pfirst ? '0 : r_term) + w_part_sh;
        end
        if (i_cmd.diff) begin
            r_sum <= '0;
        end else if (r_cv) begin
            r_sum <= r_sum + (r_term >>> FRAC_BITS);
        end
    end

    // Saturate to the 48-bit drive range
    assign w_top = r_sum[TERM_W-1:ACC_W-1];
    assign w_sat = ((&w_top) || !(|w_top)) ? r_sum[ACC_W-1:0]
                 : (r_sum[TERM_W-1] ? DRIVE_MIN : DRIVE_MAX);

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.sat_load) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.sat_load) begin
            r_drive <= w_sat;
        end
    end

    assign o_stat.out_free = !r_ovalid || i_tready;
    assign o_tvalid        = r_ovalid;
    assign o_drive         = r_drive;

endmodule

[src/pid_filtered_derivative_clamped_core.sv]
// PID controller with low-pass filtered derivative and clamped integrator.
//
// Input stream (s_axis): one beat per command. tuser[0] selects the
// command: 0 runs a control step, 1 clears the integrator and the filter
// history. tdata carries target (bits 31:0) and measured (bits 63:32),
// both signed with FRAC_BITS fraction bits.
// Output stream (m_axis): one beat per control step, none for a clear;
// tdata[47:0] is the saturated drive.
// Configuration (APB): seven registers at byte addresses 8*i, written in
// the access phase; reads return the values. The user must write them
// only while no step is in flight; the block does not enforce it.
// A step runs error, nine passes through one shared 35x18 multiplier,
// clamp, drain and saturate steps, waiting to saturate while the output
// register is full; no beat is taken until it ends. A clear does not occupy the block.
// Reset (synchronous, active low) clears integrator, history and any
// pending result and loads the register defaults.
// A stalled receiver holds the output register; the next beat is still
// accepted and computed, and waits for the register to empty.
`timescale 1ns / 1ps

module pid_filtered_derivative_clamped_core
    import pfdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [31:0] target, [63:32] measured
    input  logic [0:0]        s_axis_tuser,   // [0] cmd
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [47:0] drive
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    pfdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_tuser  (s_axis_tuser[0]),
        .o_tready (s_axis_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    pfdc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (w_cfg),
        .i_target   (s_axis_tdata[31:0]),
        .i_measured (s_axis_tdata[63:32]),
        .o_stat     (w_stat),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_drive    (m_axis_tdata)
    );

    // Never overwrite a result that the receiver has not taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sat_load |-> w_stat.out_free)
        else $error("result loaded over a pending beat");

    // A control step keeps the input closed on the next cycle
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> !s_axis_tready)
        else $error("input reopened during a control step");

    // A clear completes at once and leaves the input open
    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> s_axis_tready)
        else $error("clear beat stalled the input");

    // The multiplier runs only while a step is in flight
    a_mul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_en |-> !s_axis_tready)
        else $error("multiply issued while idle");

endmodule

[sim/testbench.sv]
// Self-checking bench for pid_filtered_derivative_clamped_core: streams command
// beats, programs the gains and clamps over APB and checks every drive beat
// against a bit-true PID predictor. Depends on pfdc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import pfdc_pkg::*;

    localparam logic CMD_STEP      = 1'b0;
    localparam logic CMD_CLEAR     = 1'b1;
    localparam int   SETTLE_CYCLES = 24;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   RANDOM_PHASES = 8;
    localparam int   PHASE_BEATS   = 155;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic               cmd;
        logic signed [31:0] target;
        logic signed [31:0] measured;
    } t_cmd_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;   // [31:0] target, [63:32] measured
    logic [0:0]        s_axis_tuser = '0;   // [0] cmd
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;        // [47:0] drive
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // Register copy and controller state as the block should hold them
    t_cfg        cfg_copy = '{32'sd0, 32'sd0, 32'sd0, 17'd0, TSTEP_RST,
                              INT_MIN_RST, INT_MAX_RST};
    longint      integ_sum = 0;
    longint      last_filt_err = 0;

    t_cmd_beat   pending_beats[$];
    logic [47:0] expected_drive[$];
    t_cmd_beat   beat_on_bus;
    t_cmd_beat   next_beat;
    logic [47:0] want;
    int          beats_queued = 0;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    pid_filtered_derivative_clamped_core #(
        .FRAC_BITS(FRAC_BITS_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] drive check: %s", $time, what);
        fail_count++;
    endtask

    // Work out the drive for one accepted beat; a clear empties the history
    task automatic advance_controller(input t_cmd_beat beat);
        longint err;
        longint weight;
        longint filt;
        longint acc;
        t_wide  total;
        if (beat.cmd == CMD_CLEAR) begin
            integ_sum     = 0;
            last_filt_err = 0;
        end else begin
            err    = longint'(beat.target) - longint'(beat.measured);
            // a weight above one acts as exactly one
            weight = (cfg_copy.fweight > WEIGHT_ONE) ? longint'(WEIGHT_ONE)
                                                     : longint'(cfg_copy.fweight);
            filt   = (weight * err + (longint'(WEIGHT_ONE) - weight) * last_filt_err)
                     >>> W_SHIFT;
            acc    = integ_sum + ((err * longint'(cfg_copy.tstep)) >>> W_SHIFT);
            // upper clamp first, so the lower bound wins when the two cross
            if (acc > longint'(cfg_copy.int_max))
                acc = longint'(cfg_copy.int_max);
            if (acc < longint'(cfg_copy.int_min))
                acc = longint'(cfg_copy.int_min);
            integ_sum = acc;
            total = ((t_wide'(cfg_copy.gain_p) * t_wide'(err)) >>> FRAC_BITS_DEF)
                  + ((t_wide'(cfg_copy.gain_i) * t_wide'(acc)) >>> FRAC_BITS_DEF)
                  + ((t_wide'(cfg_copy.gain_d) * t_wide'(filt - last_filt_err))
                     >>> FRAC_BITS_DEF);
            // saturate the exact sum to the 48-bit drive range
            if (total > t_wide'(DRIVE_MAX))
                total = t_wide'(DRIVE_MAX);
            else if (total < t_wide'($signed(DRIVE_MIN)))
                total = t_wide'($signed(DRIVE_MIN));
            expected_drive.push_back(total[47:0]);
            last_filt_err = filt;
        end
    endtask

    // Command driver: present queued beats, hold each until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                advance_controller(beat_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_beat      = pending_beats.pop_front();
                    beat_on_bus   <= next_beat;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_beat.measured, next_beat.target};
                    s_axis_tuser  <= next_beat.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Drive monitor: compare each taken beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_drive.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
                end else begin
                    want = expected_drive.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("got %h, expected %h", m_axis_tdata, want));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // APB write: setup then access, register taken when pready is seen
    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_GAIN_P:  cfg_copy.gain_p  = value[31:0];
            REG_GAIN_I:  cfg_copy.gain_i  = value[31:0];
            REG_GAIN_D:  cfg_copy.gain_d  = value[31:0];
            REG_FWEIGHT: cfg_copy.fweight = value[16:0];
            REG_TSTEP:   cfg_copy.tstep   = value[16:0];
            REG_INT_MIN: cfg_copy.int_min = value[47:0];
            REG_INT_MAX: cfg_copy.int_max = value[47:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input logic [16:0] fw,
                                 input logic [16:0] ts, input logic [47:0] lo,
                                 input logic [47:0] hi);
        write_register(REG_GAIN_P,  {32'b0, gp});
        write_register(REG_GAIN_I,  {32'b0, gi});
        write_register(REG_GAIN_D,  {32'b0, gd});
        write_register(REG_FWEIGHT, {47'b0, fw});
        write_register(REG_TSTEP,   {47'b0, ts});
        write_register(REG_INT_MIN, {16'b0, lo});
        write_register(REG_INT_MAX, {16'b0, hi});
    endtask

    task automatic push_beat(input logic cmd, input logic [31:0] target,
                             input logic [31:0] measured);
        t_cmd_beat beat;
        beat.cmd      = cmd;
        beat.target   = target;
        beat.measured = measured;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    // Hold until every beat is taken and every drive has come back, then
    // allow a trailing clear to finish
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h0;
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    initial begin
        int                 send_modes[4];
        int                 stall_modes[4];
        int                 goal;
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
        logic signed [31:0] drift;
        logic [16:0]        fw;
        logic [16:0]        ts;
        logic [47:0]        span;
        logic [47:0]        lo;
        logic [47:0]        hi;

        send_modes  = '{0, 63, 0, 7};
        stall_modes = '{0, 0, 63, 7};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero gains, yet the integrator still moves
        push_beat(CMD_STEP, 32'h0001_0000, 32'h0);
        push_beat(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        // moderate gains, tight clamps: field extremes, clamping and clear
        load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 17'h0_8000, 17'd1311,
                      -48'sd1073741824, 48'sd1073741824);
        push_beat(CMD_STEP,  32'h0,         32'h0);
        push_beat(CMD_STEP,  32'h7FFF_FFFF, 32'h8000_0000);
        push_beat(CMD_STEP,  32'h7FFF_FFFF, 32'h8000_0000);
        push_beat(CMD_STEP,  32'h8000_0000, 32'h7FFF_FFFF);
        push_beat(CMD_STEP,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_beat(CMD_STEP,  32'h8000_0000, 32'h0);
        push_beat(CMD_STEP,  32'h0,         32'h8000_0000);
        push_beat(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_beat(CMD_STEP,  32'h0001_0000, 32'h0);
        wait_idle();

        // extreme gains, unity weight and step, full clamps: drive overflow
        load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, WEIGHT_ONE, 17'h1_0000,
                      48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        push_beat(CMD_STEP,  32'h7FFF_FFFF, 32'h8000_0000);
        push_beat(CMD_STEP,  32'h7FFF_FFFF, 32'h8000_0000);
        push_beat(CMD_STEP,  32'h8000_0000, 32'h7FFF_FFFF);
        push_beat(CMD_STEP,  32'h8000_0000, 32'h7FFF_FFFF);
        push_beat(CMD_CLEAR, 32'h0,         32'h0);
        wait_idle();

        // weight above one, oversized time step, crossed clamps
        load_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 17'h1_FFFF, 17'h1_FFFF,
                      48'sd65536000, -48'sd65536000);
        push_beat(CMD_STEP,  32'h0001_0000, 32'h0);
        push_beat(CMD_STEP,  32'h8000_0000, 32'h7FFF_FFFF);
        push_beat(CMD_CLEAR, 32'h0,         32'h0);
        push_beat(CMD_STEP,  32'h0,         32'h0005_0000);
        wait_idle();

        // random phases, each with fresh settings and its own idling mode
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case ($urandom_range(0, 3))
                0:       fw = 17'd0;
                1:       fw = WEIGHT_ONE;
                2:       fw = 17'($urandom);
                default: fw = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 4))
                0:       ts = 17'd0;
                1:       ts = 17'($urandom);
                default: ts = 17'($urandom_range(0, 6554));
            endcase
            span = 48'($urandom_range(1, 32'h7FFF_FFFF)) << $urandom_range(0, 16);
            case ($urandom_range(0, 4))
                0: begin
                    lo = 48'({$urandom, $urandom});
                    hi = 48'({$urandom, $urandom});
                end
                1: begin
                    lo = 48'h8000_0000_0000;
                    hi = 48'h7FFF_FFFF_FFFF;
                end
                default: begin
                    lo = -span;
                    hi = span;
                end
            endcase
            load_settings(rand_gain(), rand_gain(), rand_gain(), fw, ts, lo, hi);

            send_idle_pct  = send_modes[phase % 4];
            recv_stall_pct = stall_modes[phase % 4];
            goal = beats_queued + PHASE_BEATS;
            while (beats_queued < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    // control run: hold a setpoint while the measurement closes in
                    if ($urandom_range(0, 2) == 0)
                        push_beat(CMD_CLEAR, $urandom, $urandom);
                    tgt  = rand_word();
                    meas = rand_word();
                    repeat ($urandom_range(4, 20)) begin
                        push_beat(CMD_STEP, tgt, meas);
                        drift = (tgt - meas) >>> 2;
                        meas  = meas + drift + 32'($urandom_range(0, 512)) - 32'd256;
                    end
                end else begin
                    push_beat(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_STEP,
                              $urandom, $urandom);
                end
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
